@@ hw/rtl/lspg_pkg.sv @@
// LED strip pattern generator: shared types, codes and the color wheel function.
// No dependencies.
`timescale 1ns / 1ps

package lspg_pkg;

	localparam int CNT_W = 7;

	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_FILL  = 2'd2;

	localparam logic [1:0] MODE_OFF     = 2'd0;
	localparam logic [1:0] MODE_SOLID   = 2'd1;
	localparam logic [1:0] MODE_RAINBOW = 2'd2;

	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILL,
		ST_FRAME
	} seq_state_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic [CNT_W-1:0] count;
		logic             clr;
	} cfg_t;

	typedef struct packed {
		logic [5:0]  index;
		logic [23:0] rgb;
		logic        last;
	} out_item_t;

	// rgb packed as {red, green, blue}
	function automatic logic [23:0] color_wheel(input logic [7:0] pos);
		logic [7:0] p;
		logic [7:0] q;
		logic [9:0] t;
		p = 8'd255 - pos;
		q = p;
		t = 10'd0;
		if (p < 8'd85) begin
			t = 10'(q) * 10'd3;
			color_wheel = {8'd255 - t[7:0], 8'd0, t[7:0]};
		end else if (p < 8'd170) begin
			q = p - 8'd85;
			t = 10'(q) * 10'd3;
			color_wheel = {8'd0, t[7:0], 8'd255 - t[7:0]};
		end else begin
			q = p - 8'd170;
			t = 10'(q) * 10'd3;
			color_wheel = {t[7:0], 8'd255 - t[7:0], 8'd0};
		end
	endfunction

endpackage

@@ hw/rtl/led_strip_pattern_generator_unit.sv @@
// LED strip pattern generator top level: stream ports, APB registers, store.
// Depends on lspg_pkg, lspg_cfg_regs, lspg_pixel_mem, lspg_out_buf, lspg_seq.
// Frame tick: the transfer starts ST_FRAME; results pass the registered store read and the
//   result buffer, one per cycle while m_tready allows (set by the single store read port);
//   busy until all reads are issued. Fill: one store write per cycle. Pixel write: stays idle.
// Reset clears all control state; store entries read black via valid flags, no sweep.
`timescale 1ns / 1ps

module led_strip_pattern_generator_unit #(
	parameter int MAX_PIXELS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // pixel_index[5:0], red_in[13:6], green_in[21:14], blue_in[29:22]
	input  logic [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // out_index[5:0], red_out[13:6], green_out[21:14], blue_out[29:22]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lspg_pkg::*;

	localparam int IW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

	cfg_t        cfg;
	logic        mem_we;
	logic [IW-1:0] mem_waddr;
	logic [23:0] mem_wdata;
	logic        mem_re;
	logic [IW-1:0] mem_raddr;
	logic [23:0] mem_rdata;
	logic [1:0]  buf_cnt;
	logic        buf_pop;
	logic        buf_push;
	out_item_t   push_item;
	out_item_t   head;

	lspg_cfg_regs #(.MAX_PIXELS(MAX_PIXELS)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lspg_pixel_mem #(.DEPTH(MAX_PIXELS), .IW(IW)) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.we        (mem_we),
		.waddr     (mem_waddr),
		.wdata     (mem_wdata),
		.re        (mem_re),
		.raddr     (mem_raddr),
		.rdata     (mem_rdata),
		.clr       (cfg.clr),
		.clr_count (cfg.count)
	);

	lspg_seq #(.IW(IW)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_func   (s_tuser),
		.in_index  (s_tdata[5:0]),
		.in_rgb    ({s_tdata[13:6], s_tdata[21:14], s_tdata[29:22]}),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.buf_cnt   (buf_cnt),
		.buf_pop   (buf_pop),
		.buf_push  (buf_push),
		.buf_item  (push_item)
	);

	lspg_out_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (buf_push),
		.push_item (push_item),
		.ready     (m_tready),
		.valid     (m_tvalid),
		.item      (head),
		.cnt       (buf_cnt),
		.pop       (buf_pop)
	);

	assign m_tdata = {2'b00, head.rgb[7:0], head.rgb[15:8], head.rgb[23:16], head.index};
	assign m_tlast = head.last;

endmodule

@@ hw/rtl/lspg_cfg_regs.sv @@
// LED strip pattern generator: APB register file (display mode, LED count).
// Depends on lspg_pkg.
`timescale 1ns / 1ps

module lspg_cfg_regs #(
	parameter int MAX_PIXELS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output lspg_pkg::cfg_t     cfg
);
	import lspg_pkg::*;

	logic [1:0]       mode_q;
	logic [CNT_W-1:0] count_q;
	logic             clr_q;
	logic             wr;
	logic             cnt_ok;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign cnt_ok = (pwdata[CNT_W-1:0] != '0) && (int'(pwdata[CNT_W-1:0]) <= MAX_PIXELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_OFF;
			count_q <= CNT_W'(MAX_PIXELS);
			clr_q   <= 1'b0;
		end else begin
			clr_q <= 1'b0;
			if (wr) begin
				case (paddr[2])
					REG_MODE: begin
						mode_q <= pwdata[1:0];
					end
					REG_COUNT: begin
						if (cnt_ok) begin
							count_q <= pwdata[CNT_W-1:0];
							clr_q   <= 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MODE:  prdata = {30'd0, mode_q};
			REG_COUNT: prdata = {{(32-CNT_W){1'b0}}, count_q};
			default:   prdata = 32'd0;
		endcase
	end

	assign cfg.mode  = mode_q;
	assign cfg.count = count_q;
	assign cfg.clr   = clr_q;

endmodule

@@ hw/rtl/lspg_pixel_mem.sv @@
// LED strip pattern generator: pixel color store, one write and one read port,
// registered read, per-entry valid flags so unwritten entries read black.
// Depends on lspg_pkg.
`timescale 1ns / 1ps

module lspg_pixel_mem #(
	parameter int DEPTH = 64,
	parameter int IW    = 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [IW-1:0]            waddr,
	input  logic [23:0]              wdata,
	input  logic                     re,
	input  logic [IW-1:0]            raddr,
	output logic [23:0]              rdata,
	input  logic                     clr,
	input  logic [lspg_pkg::CNT_W-1:0] clr_count
);
	import lspg_pkg::*;

	logic [23:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [23:0] rd_q;
	logic        rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (clr) begin
				for (int i = 0; i < DEPTH; i++) begin
					if (i >= int'(clr_count)) begin
						vld_q[i] <= 1'b0;
					end
				end
			end
			if (re) begin
				rd_vld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_q : 24'd0;

endmodule

@@ hw/rtl/lspg_out_buf.sv @@
// LED strip pattern generator: two-entry result buffer between the read
// pipeline and the output stream. Depends on lspg_pkg.
`timescale 1ns / 1ps

module lspg_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lspg_pkg::out_item_t push_item,
	input  logic                ready,
	output logic                valid,
	output lspg_pkg::out_item_t item,
	output logic [1:0]          cnt,
	output logic                pop
);
	import lspg_pkg::*;

	out_item_t ent_q [2];
	logic      wp_q;
	logic      rp_q;
	logic [1:0] cnt_q;

	assign valid = (cnt_q != 2'd0);
	assign item  = ent_q[rp_q];
	assign pop   = valid & ready;
	assign cnt   = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ hw/rtl/lspg_seq.sv @@
// LED strip pattern generator: item sequencer. Handles the input transfer,
// fill sweep, frame read pipeline and rainbow offset. Depends on lspg_pkg.
`timescale 1ns / 1ps

module lspg_seq #(
	parameter int IW = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lspg_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          in_func,
	input  logic [5:0]          in_index,
	input  logic [23:0]         in_rgb,
	output logic                mem_we,
	output logic [IW-1:0]       mem_waddr,
	output logic [23:0]         mem_wdata,
	output logic                mem_re,
	output logic [IW-1:0]       mem_raddr,
	input  logic [23:0]         mem_rdata,
	input  logic [1:0]          buf_cnt,
	input  logic                buf_pop,
	output logic                buf_push,
	output lspg_pkg::out_item_t buf_item
);
	import lspg_pkg::*;

	seq_state_t       state_q, state_d;
	logic [CNT_W-1:0] ctr_q;
	logic [23:0]      fill_q;
	logic [7:0]       offset_q;
	logic             ctr_last;
	logic             can_issue;
	logic             accept;

	logic             v_s1;
	logic [5:0]       idx_s1;
	logic [7:0]       pos_s1;
	logic             last_s1;

	assign accept    = in_valid & in_ready;
	assign ctr_last  = ((ctr_q + CNT_W'(1)) == cfg.count);
	assign can_issue = (({1'b0, buf_cnt} + {2'b0, v_s1}) <= (3'd1 + {2'b0, buf_pop}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = (state_q == ST_IDLE);
		mem_we    = 1'b0;
		mem_waddr = in_index[IW-1:0];
		mem_wdata = in_rgb;
		mem_re    = 1'b0;
		mem_raddr = ctr_q[IW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_func)
						FUNC_TICK:  state_d = ST_FRAME;
						FUNC_WRITE: mem_we  = ({1'b0, in_index} < cfg.count);
						FUNC_FILL:  state_d = ST_FILL;
						default: ;
					endcase
				end
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = ctr_q[IW-1:0];
				mem_wdata = fill_q;
				if (ctr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_FRAME: begin
				if (can_issue) begin
					mem_re = 1'b1;
					if (ctr_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q    <= '0;
			offset_q <= 8'd0;
			v_s1     <= 1'b0;
		end else begin
			v_s1 <= mem_re;
			case (state_q)
				ST_IDLE: ctr_q <= '0;
				ST_FILL: ctr_q <= ctr_q + CNT_W'(1);
				ST_FRAME: begin
					if (can_issue) begin
						ctr_q <= ctr_q + CNT_W'(1);
						if (ctr_last && cfg.mode == MODE_RAINBOW) begin
							offset_q <= offset_q + 8'd1;
						end
					end
				end
				default: ctr_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fill_q <= in_rgb;
		end
		if (mem_re) begin
			idx_s1  <= ctr_q[5:0];
			pos_s1  <= 8'({1'b0, ctr_q} + offset_q);
			last_s1 <= ctr_last;
		end
	end

	assign buf_push       = v_s1;
	assign buf_item.index = idx_s1;
	assign buf_item.last  = last_s1;

	always_comb begin
		case (cfg.mode)
			MODE_SOLID:   buf_item.rgb = mem_rdata;
			MODE_RAINBOW: buf_item.rgb = color_wheel(pos_s1);
			default:      buf_item.rgb = 24'd0;
		endcase
	end

	a_idle_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mem_re)
		else $error("read issued while idle");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("store written and read in the same cycle");

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(({1'b0, buf_cnt} + {2'b0, v_s1}) <= 3'd2))
		else $error("result buffer overcommitted");

	a_offset_step: assert property (@(posedge clk) disable iff (!arst_n)
		(offset_q != $past(offset_q)) |->
		($past(state_q) == ST_FRAME && $past(cfg.mode) == MODE_RAINBOW))
		else $error("rainbow offset moved outside a rainbow frame");

endmodule

@@ tb/tb_led_strip_pattern_generator_unit.sv @@
// Testbench for led_strip_pattern_generator_unit: directed and random pixel streams,
// checked per transfer against an in-bench model of the store, mode and rainbow offset.
// Depends on lspg_pkg and the RTL under hw/rtl.
`timescale 1ns / 1ps

module tb_led_strip_pattern_generator_unit;

	import lspg_pkg::*;

	localparam logic [1:0] FUNC_UNUSED   = 2'd3;
	localparam logic [1:0] MODE_RESERVED = 2'd3;
	localparam int NUM_PIXELS  = 64;
	localparam int BUSY_CYCLES = 80;
	localparam int QUIET_LIMIT = 4000;

	typedef struct packed {
		logic [5:0] idx;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // pixel_index[5:0], red_in[13:6], green_in[21:14], blue_in[29:22]
	logic [1:0]  s_tuser;  // func[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;  // out_index[5:0], red_out[13:6], green_out[21:14], blue_out[29:22]
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// model state
	logic [23:0] pixel_model [NUM_PIXELS];
	logic [7:0]  wheel_offset;
	logic [1:0]  mode_q;
	logic [6:0]  led_count_q;
	pixel_t      pending_pixels [$];

	int mismatches = 0;
	int quiet_cycles = 0;
	int stall_left = 0;
	bit rx_stalls_on = 1'b0;
	bit tx_gaps_on = 1'b0;

	led_strip_pattern_generator_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [23:0] wheel_rgb(input logic [7:0] pos);
		int p;
		p = 255 - int'(pos);
		if (p < 85)
			return {8'(255 - 3 * p), 8'h00, 8'(3 * p)};
		if (p < 170)
			return {8'h00, 8'(3 * (p - 85)), 8'(255 - 3 * (p - 85))};
		return {8'(3 * (p - 170)), 8'(255 - 3 * (p - 170)), 8'h00};
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 19) < 16)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("ERROR %0t: %s got %0h want %0h", $time, field, got, want);
		mismatches++;
	endtask

	task automatic reset_model();
		for (int i = 0; i < NUM_PIXELS; i++)
			pixel_model[i] = 24'h0;
		wheel_offset = 8'h0;
		mode_q = MODE_OFF;
		led_count_q = 7'd64;
	endtask

	task automatic apply_register(input logic reg_sel, input logic [31:0] value);
		logic [6:0] cnt;
		cnt = value[6:0];
		if (reg_sel == REG_MODE) begin
			mode_q = value[1:0];
		end else if (cnt != 0 && cnt <= NUM_PIXELS) begin
			led_count_q = cnt;
			for (int i = int'(cnt); i < NUM_PIXELS; i++)
				pixel_model[i] = 24'h0;
		end
	endtask

	task automatic predict_pixels(input logic [1:0] fn, input logic [5:0] idx,
			input logic [23:0] rgb);
		pixel_t     px;
		logic [23:0] c;
		case (fn)
			FUNC_WRITE: begin
				if (idx < led_count_q)
					pixel_model[idx] = rgb;
			end
			FUNC_FILL: begin
				for (int i = 0; i < led_count_q; i++)
					pixel_model[i] = rgb;
			end
			FUNC_TICK: begin
				for (int i = 0; i < led_count_q; i++) begin
					if (mode_q == MODE_SOLID)
						c = pixel_model[i];
					else if (mode_q == MODE_RAINBOW)
						c = wheel_rgb(8'(i + int'(wheel_offset)));
					else
						c = 24'h0;
					px.idx   = 6'(i);
					px.red   = c[23:16];
					px.green = c[15:8];
					px.blue  = c[7:0];
					px.last  = (i + 1 == int'(led_count_q));
					pending_pixels.push_back(px);
				end
				if (mode_q == MODE_RAINBOW)
					wheel_offset = wheel_offset + 8'd1;
			end
			default: begin
			end
		endcase
	endtask

	// called at a rising edge; returns at the edge of the transfer with s_tvalid still high
	task automatic send_item(input logic [1:0] fn, input logic [5:0] idx,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int gap;
		gap = 0;
		if (tx_gaps_on && $urandom_range(0, 9) >= 6)
			gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= {2'b00, b, g, r, idx};
		do @(posedge clk); while (!s_tready);
		predict_pixels(fn, idx, {r, g, b});
	endtask

	task automatic drain_outputs();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
	endtask

	// fills and writes leave nothing to wait on, so allow the busy time on top
	task automatic wait_idle();
		drain_outputs();
		repeat (BUSY_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic reg_sel, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		apply_register(reg_sel, value);
		@(posedge clk);
	endtask

	task automatic random_item(input int tick_pct);
		int         sel;
		logic [1:0] fn;
		logic [5:0] idx;
		sel = $urandom_range(0, 99);
		if (sel < tick_pct)
			fn = FUNC_TICK;
		else if (sel < tick_pct + (100 - tick_pct) / 2)
			fn = FUNC_WRITE;
		else if (sel < 95)
			fn = FUNC_FILL;
		else
			fn = FUNC_UNUSED;
		if ($urandom_range(0, 1) == 1)
			idx = 6'($urandom_range(0, int'(led_count_q) - 1));
		else
			idx = 6'($urandom_range(0, 63));
		send_item(fn, idx, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		if ($urandom_range(0, 99) < 3)
			drain_outputs();
	endtask

	task automatic test_reset_state();
		tx_gaps_on = 1'b0;
		rx_stalls_on <= 1'b0;
		send_item(FUNC_TICK, 6'd0, 8'h00, 8'h00, 8'h00);
		wait_idle();
		apb_write(REG_MODE, 32'(MODE_SOLID));
		send_item(FUNC_TICK, 6'd63, 8'hff, 8'hff, 8'hff);
	endtask

	task automatic test_store_writes();
		tx_gaps_on = 1'b1;
		rx_stalls_on <= 1'b1;
		send_item(FUNC_WRITE, 6'd63, 8'hff, 8'hff, 8'hff);
		send_item(FUNC_WRITE, 6'd0, 8'hff, 8'h00, 8'h00);
		send_item(FUNC_WRITE, 6'd1, 8'h00, 8'hff, 8'h00);
		send_item(FUNC_WRITE, 6'd2, 8'h00, 8'h00, 8'hff);
		send_item(FUNC_TICK, 6'd0, 8'h00, 8'h00, 8'h00);
		send_item(FUNC_FILL, 6'd0, 8'haa, 8'h55, 8'h0f);
		send_item(FUNC_WRITE, 6'd0, 8'h00, 8'h00, 8'h00);
		send_item(FUNC_TICK, 6'd0, 8'h00, 8'h00, 8'h00);
		send_item(FUNC_UNUSED, 6'd63, 8'hff, 8'hff, 8'hff);
		send_item(FUNC_TICK, 6'd0, 8'h00, 8'h00, 8'h00);
	endtask

	task automatic test_count_limits();
		wait_idle();
		apb_write(REG_COUNT, 32'd0);
		apb_write(REG_COUNT, 32'd65);
		apb_write(REG_COUNT, 32'd127);
		send_item(FUNC_TICK, 6'd0, 8'h00, 8'h00, 8'h00);
		wait_idle();
		apb_write(REG_COUNT, 32'd10);
		send_item(FUNC_WRITE, 6'd10, 8'h12, 8'h34, 8'h56);
		send_item(FUNC_WRITE, 6'd9, 8'h12, 8'h34, 8'h56);
		send_item(FUNC_TICK, 6'd0, 8'h00, 8'h00, 8'h00);
		wait_idle();
		apb_write(REG_COUNT, 32'd64);
		send_item(FUNC_TICK, 6'd0, 8'h00, 8'h00, 8'h00);
		wait_idle();
		apb_write(REG_COUNT, 32'd1);
		send_item(FUNC_TICK, 6'd0, 8'h00, 8'h00, 8'h00);
	endtask

	task automatic test_modes();
		wait_idle();
		apb_write(REG_MODE, 32'(MODE_RESERVED));
		apb_write(REG_COUNT, 32'd5);
		send_item(FUNC_TICK, 6'd0, 8'h00, 8'h00, 8'h00);
		wait_idle();
		apb_write(REG_MODE, 32'(MODE_RAINBOW));
		apb_write(REG_COUNT, 32'd64);
		send_item(FUNC_TICK, 6'd0, 8'h00, 8'h00, 8'h00);
		send_item(FUNC_FILL, 6'd0, 8'h01, 8'h02, 8'h03);
		send_item(FUNC_TICK, 6'd0, 8'h00, 8'h00, 8'h00);
		wait_idle();
		apb_write(REG_MODE, 32'(MODE_OFF));
		send_item(FUNC_TICK, 6'd0, 8'h00, 8'h00, 8'h00);
	endtask

	// long rainbow run so the wheel position (index plus offset) wraps past the end of the wheel
	task automatic test_rainbow_sweep();
		wait_idle();
		apb_write(REG_MODE, 32'(MODE_RAINBOW));
		apb_write(REG_COUNT, 32'd64);
		tx_gaps_on = 1'b1;
		rx_stalls_on <= 1'b0;
		for (int n = 0; n < 210; n++) begin
			if (n == 100)
				rx_stalls_on <= 1'b1;
			random_item(97);
		end
	endtask

	task automatic test_random_phases();
		logic [1:0] modes [5];
		logic [1:0] m;
		int         cnt;
		modes = '{MODE_OFF, MODE_SOLID, MODE_SOLID, MODE_RAINBOW, MODE_RESERVED};
		for (int ph = 0; ph < 4; ph++) begin
			wait_idle();
			m = (ph == 1) ? MODE_SOLID : modes[$urandom_range(0, 4)];
			cnt = (ph == 0) ? 1 : (ph == 1) ? 64 : $urandom_range(2, 63);
			apb_write(REG_MODE, 32'(m));
			if ($urandom_range(0, 1) == 1)
				apb_write(REG_COUNT, 32'($urandom_range(65, 127)));
			apb_write(REG_COUNT, 32'(cnt));
			tx_gaps_on = ($urandom_range(0, 3) != 0);
			rx_stalls_on <= ($urandom_range(0, 3) != 0);
			for (int n = 0; n < 15; n++)
				random_item(30);
		end
	endtask

	always @(posedge clk) begin : pixel_check
		pixel_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("pixel with none pending", m_tdata, 32'h0);
			end else begin
				e = pending_pixels.pop_front();
				if (m_tdata[5:0] !== e.idx)
					report_mismatch("out_index", m_tdata[5:0], e.idx);
				if (m_tdata[13:6] !== e.red)
					report_mismatch("red_out", m_tdata[13:6], e.red);
				if (m_tdata[21:14] !== e.green)
					report_mismatch("green_out", m_tdata[21:14], e.green);
				if (m_tdata[29:22] !== e.blue)
					report_mismatch("blue_out", m_tdata[29:22], e.blue);
				if (m_tlast !== e.last)
					report_mismatch("last_pixel", m_tlast, e.last);
			end
		end
		if (!rx_stalls_on) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = pick_gap() - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		s_tvalid <= 1'b0;
		s_tdata  <= 32'h0;
		s_tuser  <= FUNC_TICK;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= 3'd0;
		pwdata   <= 32'h0;
		reset_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_store_writes();
		test_count_limits();
		test_modes();
		test_rainbow_sweep();
		test_random_phases();
		wait_idle();

		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ led_strip_pattern_generator_unit.f @@
hw/rtl/lspg_pkg.sv
hw/rtl/lspg_cfg_regs.sv
hw/rtl/lspg_pixel_mem.sv
hw/rtl/lspg_out_buf.sv
hw/rtl/lspg_seq.sv
hw/rtl/led_strip_pattern_generator_unit.sv
tb/tb_led_strip_pattern_generator_unit.sv
